@@ design/mrmf_pkg.sv @@
// Shared types, constants and functions of the Modbus RTU master framer.
// No dependencies; used by mrmf_core, mrmf_outbuf and the top level.

package mrmf_pkg;

    // Input operation codes
    localparam logic [1:0] OP_REQ  = 2'd0;
    localparam logic [1:0] OP_RX   = 2'd1;
    localparam logic [1:0] OP_TICK = 2'd2;

    // Result kinds
    localparam logic [1:0] KIND_TX     = 2'd0;
    localparam logic [1:0] KIND_RX     = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    // Frame status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NO_REPLY  = 3'd1;
    localparam logic [2:0] ST_SHORT     = 3'd2;
    localparam logic [2:0] ST_CRC_ERROR = 3'd3;
    localparam logic [2:0] ST_EXCEPTION = 3'd4;

    // Configuration register indexes
    localparam logic REG_TIMEOUT = 1'b0;
    localparam logic REG_GAP     = 1'b1;

    localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
    localparam logic [7:0]  GAP_RESET     = 8'd4;

    localparam logic [15:0] CRC_INIT  = 16'hFFFF;
    localparam logic [15:0] CRC_POLY  = 16'hA001;
    localparam int          EXC_BIT   = 7;
    localparam logic [8:0]  MIN_FRAME = 9'd4;
    localparam logic [15:0] SIL_MAX   = 16'hFFFF;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_WAIT = 2'd1,
        PH_RECV = 2'd2
    } t_phase;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] byte_value;
        logic       end_of_run;
        logic [2:0] status;
        logic [7:0] exception_code;
        logic [8:0] frame_length;
    } t_result;

    // Up to three results raised by one transaction
    typedef struct packed {
        logic [1:0]        count;
        t_result [2:0]     res;
    } t_batch;

    // One byte folded into CRC-16 with the reflected polynomial
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic t_result byte_result(input logic [1:0] kind, input logic [7:0] b,
                                            input logic eor);
        t_result r;
        r = '0;
        r.kind       = kind;
        r.byte_value = b;
        r.end_of_run = eor;
        return r;
    endfunction

    // Closing status of a reply frame; always the final result of its transaction
    function automatic t_result close_result(input logic [8:0] cnt, input logic [15:0] crc,
                                             input logic [7:0] fn, input logic [7:0] third);
        t_result r;
        r = '0;
        r.kind         = KIND_STATUS;
        r.end_of_run   = 1'b1;
        r.frame_length = cnt;
        if (cnt == 9'd0) begin
            r.status = ST_NO_REPLY;
        end else if (cnt < MIN_FRAME) begin
            r.status = ST_SHORT;
        end else if (crc != 16'd0) begin
            r.status = ST_CRC_ERROR;
        end else if (fn[EXC_BIT]) begin
            r.status         = ST_EXCEPTION;
            r.exception_code = third;
        end else begin
            r.status = ST_OK;
        end
        return r;
    endfunction

endpackage

@@ design/mrmf_core.sv @@
// Framing state and per-transaction result builder of the Modbus RTU master framer.
// Depends on mrmf_pkg.

module mrmf_core #(
    parameter int MAX_FRAME = 256
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  logic [1:0]           i_op,
    input  logic [7:0]           i_data_byte,
    input  logic                 i_last_request_byte,
    input  logic [15:0]          i_reply_timeout_ticks,
    input  logic [7:0]           i_gap_ticks,
    output mrmf_pkg::t_batch     o_batch
);

    localparam logic [8:0] MAX_COUNT = 9'(MAX_FRAME);

    mrmf_pkg::t_phase r_phase, n_phase;
    logic [15:0] r_crc, n_crc;
    logic [8:0]  r_count, n_count;
    logic [15:0] r_sil, n_sil;
    logic [7:0]  r_fn, n_fn;
    logic [7:0]  r_third, n_third;

    logic [15:0] crc_nxt;
    logic [8:0]  cnt_nxt;
    logic [15:0] sil_nxt;
    logic [15:0] limit;
    logic [7:0]  fn_nxt;
    logic [7:0]  third_nxt;
    mrmf_pkg::t_batch batch;

    assign crc_nxt   = mrmf_pkg::crc_byte(r_crc, i_data_byte);
    assign cnt_nxt   = r_count + 9'd1;
    assign sil_nxt   = (r_sil == mrmf_pkg::SIL_MAX) ? r_sil : r_sil + 16'd1;
    assign limit     = (r_phase == mrmf_pkg::PH_WAIT) ? i_reply_timeout_ticks
                                                      : {8'h00, i_gap_ticks};
    assign fn_nxt    = (cnt_nxt == 9'd2) ? i_data_byte : r_fn;
    assign third_nxt = (cnt_nxt == 9'd3) ? i_data_byte : r_third;

    always_comb begin
        n_phase = r_phase;
        n_crc   = r_crc;
        n_count = r_count;
        n_sil   = r_sil;
        n_fn    = r_fn;
        n_third = r_third;
        batch   = '0;
        unique case (i_op)
            mrmf_pkg::OP_REQ: begin
                if (r_phase == mrmf_pkg::PH_IDLE) begin
                    n_crc        = crc_nxt;
                    batch.count  = 2'd1;
                    batch.res[0] = mrmf_pkg::byte_result(mrmf_pkg::KIND_TX, i_data_byte,
                                                         !i_last_request_byte);
                    if (i_last_request_byte) begin
                        batch.count  = 2'd3;
                        batch.res[1] = mrmf_pkg::byte_result(mrmf_pkg::KIND_TX,
                                                             crc_nxt[7:0], 1'b0);
                        batch.res[2] = mrmf_pkg::byte_result(mrmf_pkg::KIND_TX,
                                                             crc_nxt[15:8], 1'b1);
                        n_phase = mrmf_pkg::PH_WAIT;
                        n_crc   = mrmf_pkg::CRC_INIT;
                        n_count = '0;
                        n_sil   = '0;
                        n_fn    = '0;
                        n_third = '0;
                    end
                end
            end
            mrmf_pkg::OP_RX: begin
                if (r_phase != mrmf_pkg::PH_IDLE) begin
                    n_crc        = crc_nxt;
                    n_count      = cnt_nxt;
                    n_fn         = fn_nxt;
                    n_third      = third_nxt;
                    n_sil        = '0;
                    n_phase      = mrmf_pkg::PH_RECV;
                    batch.count  = 2'd1;
                    batch.res[0] = mrmf_pkg::byte_result(mrmf_pkg::KIND_RX, i_data_byte,
                                                         cnt_nxt < MAX_COUNT);
                    if (cnt_nxt >= MAX_COUNT) begin
                        // Frame full: status follows the echoed byte at once
                        batch.count  = 2'd2;
                        batch.res[1] = mrmf_pkg::close_result(cnt_nxt, crc_nxt,
                                                              fn_nxt, third_nxt);
                        n_phase = mrmf_pkg::PH_IDLE;
                        n_crc   = mrmf_pkg::CRC_INIT;
                        n_count = '0;
                        n_fn    = '0;
                        n_third = '0;
                    end
                end
            end
            mrmf_pkg::OP_TICK: begin
                if (r_phase != mrmf_pkg::PH_IDLE) begin
                    n_sil = sil_nxt;
                    if (sil_nxt >= limit) begin
                        batch.count  = 2'd1;
                        batch.res[0] = mrmf_pkg::close_result(r_count, r_crc, r_fn, r_third);
                        n_phase = mrmf_pkg::PH_IDLE;
                        n_crc   = mrmf_pkg::CRC_INIT;
                        n_count = '0;
                        n_sil   = '0;
                        n_fn    = '0;
                        n_third = '0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign o_batch = batch;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= mrmf_pkg::PH_IDLE;
            r_crc   <= mrmf_pkg::CRC_INIT;
            r_count <= '0;
            r_sil   <= '0;
            r_fn    <= '0;
            r_third <= '0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_crc   <= n_crc;
            r_count <= n_count;
            r_sil   <= n_sil;
            r_fn    <= n_fn;
            r_third <= n_third;
        end
    end

endmodule

@@ design/mrmf_outbuf.sv @@
// Result register of the Modbus RTU master framer: holds up to three results of one
// transaction and hands them out one per cycle unless stalled. Depends on mrmf_pkg.

module mrmf_outbuf (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  mrmf_pkg::t_batch     i_batch,
    input  logic                 i_out_stall,
    output logic                 o_in_stall,
    output logic                 o_out_valid,
    output mrmf_pkg::t_result    o_result
);

    mrmf_pkg::t_result [2:0] r_res;
    logic [1:0] r_cnt;
    logic [1:0] r_idx;
    logic       take;
    logic       last_take;

    assign o_out_valid = (r_idx != r_cnt);
    assign take        = o_out_valid && !i_out_stall;
    assign last_take   = take && (r_idx == r_cnt - 2'd1);
    // A new transaction may enter once the buffer empties in this cycle
    assign o_in_stall  = o_out_valid && !last_take;
    assign o_result    = r_res[r_idx];

    always_ff @(posedge i_clk) begin
        if (i_accept && i_batch.count != 2'd0) begin
            r_res <= i_batch.res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_idx <= '0;
        end else if (i_accept && i_batch.count != 2'd0) begin
            r_cnt <= i_batch.count;
            r_idx <= '0;
        end else if (last_take) begin
            r_cnt <= '0;
            r_idx <= '0;
        end else if (take) begin
            r_idx <= r_idx + 2'd1;
        end
    end

endmodule

@@ design/modbus_rtu_master_framer_top.sv @@
// Top level of the Modbus RTU master framer: APB register file, framing core and
// result register. Depends on mrmf_pkg, mrmf_core and mrmf_outbuf.
//
// Usage. The input channel (i_in_valid / o_in_stall) carries one transaction per
// item: a request byte, a byte received from the line, or a one-millisecond tick.
// The output channel (o_out_valid / i_out_stall) carries results: transmit bytes,
// echoed reply bytes and the closing frame status, with o_end_of_run set on the
// final result of each input transaction.
// The core updates its state and builds all results of an accepted transaction at
// the accepting edge; the first result is presented in the following cycle. With
// the receiver not stalling, throughput is one input transaction per cycle while
// each raises at most one result; the final request byte raises three results and
// a byte that fills the frame raises two, and the result register hands them out
// one per cycle while not stalled, holding the input channel off meanwhile.
// When the receiver stalls, the pending result is held steady and o_in_stall rises
// once the result register is occupied; a new transaction enters in the same cycle
// as the last pending result is taken.
// Reset (synchronous, active low) idles the core with the CRC at 0xFFFF, empties
// the result register and loads the timeout and gap registers with their defaults;
// no clearing pass. The user must write registers only while idle (not enforced).

module modbus_rtu_master_framer_top #(
    parameter int MAX_FRAME = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_op,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_request_byte,
    // Output channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_byte_value,
    output logic        o_end_of_run,
    output logic [2:0]  o_status,
    output logic [7:0]  o_exception_code,
    output logic [8:0]  o_frame_length,
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [15:0] r_reply_timeout_ticks;
    logic [7:0]  r_gap_ticks;
    logic        cfg_write;
    logic        in_accept;
    mrmf_pkg::t_batch  batch;
    mrmf_pkg::t_result result;

    // Register file: the register index is the word address bit
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reply_timeout_ticks <= mrmf_pkg::TIMEOUT_RESET;
            r_gap_ticks           <= mrmf_pkg::GAP_RESET;
        end else if (cfg_write) begin
            unique case (paddr[2])
                mrmf_pkg::REG_TIMEOUT: r_reply_timeout_ticks <= pwdata[15:0];
                mrmf_pkg::REG_GAP:     r_gap_ticks           <= pwdata[7:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            mrmf_pkg::REG_TIMEOUT: prdata = {16'h0000, r_reply_timeout_ticks};
            mrmf_pkg::REG_GAP:     prdata = {24'h000000, r_gap_ticks};
            default:               prdata = '0;
        endcase
    end

    assign in_accept = i_in_valid && !o_in_stall;

    mrmf_core #(
        .MAX_FRAME(MAX_FRAME)
    ) u_core (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_accept              (in_accept),
        .i_op                  (i_op),
        .i_data_byte           (i_data_byte),
        .i_last_request_byte   (i_last_request_byte),
        .i_reply_timeout_ticks (r_reply_timeout_ticks),
        .i_gap_ticks           (r_gap_ticks),
        .o_batch               (batch)
    );

    mrmf_outbuf u_outbuf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_accept),
        .i_batch     (batch),
        .i_out_stall (i_out_stall),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_result    (result)
    );

    assign o_kind           = result.kind;
    assign o_byte_value     = result.byte_value;
    assign o_end_of_run     = result.end_of_run;
    assign o_status         = result.status;
    assign o_exception_code = result.exception_code;
    assign o_frame_length   = result.frame_length;

    // A transaction is only taken when no earlier result would be overwritten.
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |-> (!o_out_valid || (!i_out_stall && o_end_of_run)))
        else $error("input taken while results still pending");

    // A frame status is always the last result of its transaction.
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_kind == mrmf_pkg::KIND_STATUS) |-> o_end_of_run)
        else $error("frame status not marked as final result");

    // A reply frame never reports more bytes than the frame limit.
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_frame_length <= 9'(MAX_FRAME)))
        else $error("frame length beyond limit");

    // After a non-final result is taken, another result follows at once.
    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && !o_end_of_run) |=> o_out_valid)
        else $error("run of results broken off");

endmodule

@@ verif/mrmf_tb_pkg.sv @@
// Scoreboard for the Modbus RTU master framer testbench: a bit-accurate model of the
// framer together with the queue of results it still has to see. Depends on mrmf_pkg.

package mrmf_tb_pkg;

    import mrmf_pkg::*;

    localparam int FRAME_MAX = 256;

    class frame_scoreboard;

        // Configuration as last written
        logic [15:0] timeout_ticks;
        logic [7:0]  gap_ticks;

        // Framing state
        t_phase      ph;
        logic [15:0] crc;
        logic [8:0]  reply_len;
        logic [15:0] quiet_ticks;
        logic [7:0]  fn_byte;
        logic [7:0]  third_byte;

        t_result     awaited[$];
        int          errors;
        int          results_seen;

        function new();
            timeout_ticks = TIMEOUT_RESET;
            gap_ticks     = GAP_RESET;
            errors        = 0;
            results_seen  = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            ph          = PH_IDLE;
            crc         = CRC_INIT;
            reply_len   = '0;
            quiet_ticks = '0;
            fn_byte     = '0;
            third_byte  = '0;
        endfunction

        function void set_register(logic index, logic [31:0] value);
            if (index == REG_TIMEOUT) begin
                timeout_ticks = value[15:0];
            end else begin
                gap_ticks = value[7:0];
            end
        endfunction

        // CRC-16 over one byte, taken a bit at a time, least significant bit first.
        static function logic [15:0] fold(logic [15:0] c, logic [7:0] b);
            logic fb;
            for (int i = 0; i < 8; i++) begin
                fb = c[0] ^ b[i];
                c  = c >> 1;
                if (fb) begin
                    c = c ^ 16'hA001;
                end
            end
            return c;
        endfunction

        function t_result line_byte(logic [1:0] kind, logic [7:0] b);
            t_result r;
            r            = '0;
            r.kind       = kind;
            r.byte_value = b;
            return r;
        endfunction

        // Status that closes the current reply frame; returns the framer to idle.
        function t_result frame_status();
            t_result r;
            r              = '0;
            r.kind         = KIND_STATUS;
            r.frame_length = reply_len;
            if (reply_len == 0) begin
                r.status = ST_NO_REPLY;
            end else if (reply_len < 4) begin
                r.status = ST_SHORT;
            end else if (crc != 16'h0000) begin
                r.status = ST_CRC_ERROR;
            end else if (fn_byte[7]) begin
                r.status         = ST_EXCEPTION;
                r.exception_code = third_byte;
            end else begin
                r.status = ST_OK;
            end
            clear_frame();
            return r;
        endfunction

        // Notes an accepted input transaction and queues the results it causes.
        // Returns 0 when the framer simply ignores the transaction.
        function bit accept_item(logic [1:0] op, logic [7:0] b, logic last);
            t_result     fresh[3];
            int          n;
            logic [15:0] limit;
            n = 0;
            case (op)
                OP_REQ: begin
                    if (ph != PH_IDLE) begin
                        return 1'b0;
                    end
                    crc      = fold(crc, b);
                    fresh[n] = line_byte(KIND_TX, b);
                    n++;
                    if (last) begin
                        fresh[n]     = line_byte(KIND_TX, crc[7:0]);
                        fresh[n + 1] = line_byte(KIND_TX, crc[15:8]);
                        n += 2;
                        clear_frame();
                        ph = PH_WAIT;
                    end
                end
                OP_RX: begin
                    if (ph == PH_IDLE) begin
                        return 1'b0;
                    end
                    crc       = fold(crc, b);
                    reply_len = reply_len + 1;
                    if (reply_len == 2) begin
                        fn_byte = b;
                    end else if (reply_len == 3) begin
                        third_byte = b;
                    end
                    quiet_ticks = '0;
                    ph          = PH_RECV;
                    fresh[n]    = line_byte(KIND_RX, b);
                    n++;
                    if (reply_len >= FRAME_MAX) begin
                        fresh[n] = frame_status();
                        n++;
                    end
                end
                OP_TICK: begin
                    if (ph == PH_IDLE) begin
                        return 1'b0;
                    end
                    if (quiet_ticks != 16'hFFFF) begin
                        quiet_ticks = quiet_ticks + 1;
                    end
                    limit = (ph == PH_WAIT) ? timeout_ticks : {8'h00, gap_ticks};
                    if (quiet_ticks >= limit) begin
                        fresh[n] = frame_status();
                        n++;
                    end
                end
                default: begin
                    return 1'b0;
                end
            endcase
            if (n > 0) begin
                fresh[n - 1].end_of_run = 1'b1;
            end
            for (int i = 0; i < n; i++) begin
                awaited.push_back(fresh[i]);
            end
            return 1'b1;
        endfunction

        task report(string what);
            $display("ERROR: result %0d: %s", results_seen, what);
            errors++;
        endtask

        task check_result(t_result got);
            t_result want;
            results_seen++;
            if (awaited.size() == 0) begin
                report($sformatf("unexpected result, kind %0d byte %02h status %0d",
                                 got.kind, got.byte_value, got.status));
                return;
            end
            want = awaited.pop_front();
            if (got.kind !== want.kind)
                report($sformatf("kind %0d, expected %0d", got.kind, want.kind));
            if (got.byte_value !== want.byte_value)
                report($sformatf("byte %02h, expected %02h", got.byte_value, want.byte_value));
            if (got.end_of_run !== want.end_of_run)
                report($sformatf("end_of_run %b, expected %b", got.end_of_run, want.end_of_run));
            if (got.status !== want.status)
                report($sformatf("status %0d, expected %0d", got.status, want.status));
            if (got.exception_code !== want.exception_code)
                report($sformatf("exception code %02h, expected %02h",
                                 got.exception_code, want.exception_code));
            if (got.frame_length !== want.frame_length)
                report($sformatf("frame length %0d, expected %0d",
                                 got.frame_length, want.frame_length));
        endtask

        task leftover_check();
            if (awaited.size() != 0) begin
                report($sformatf("%0d expected results never arrived", awaited.size()));
            end
        endtask

    endclass

endpackage

@@ verif/tb_top.sv @@
// Top level of the Modbus RTU master framer testbench: clock, reset, stimulus, the
// result monitor and the run watchdog. Depends on mrmf_pkg, mrmf_tb_pkg and the RTL.

module tb_top;

    import mrmf_pkg::*;
    import mrmf_tb_pkg::*;

    // The watchdog limit sits far above the slowest correct run: a few hundred
    // transactions, each raising at most three results under the heaviest stalls.
    localparam int unsigned RUN_LIMIT = 1000000;
    localparam int          PHASE_ITEMS = 12;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [1:0]  i_op = OP_TICK;
    logic [7:0]  i_data_byte = 8'h00;
    logic        i_last_request_byte = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [1:0]  o_kind;
    logic [7:0]  o_byte_value;
    logic        o_end_of_run;
    logic [2:0]  o_status;
    logic [7:0]  o_exception_code;
    logic [8:0]  o_frame_length;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = 3'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    frame_scoreboard sb = new();

    // Sender pacing: bursts of transactions separated by random pauses, unless a
    // steady stretch has been chosen.
    int          burst_left = 0;
    bit          steady = 1'b0;
    int          live_items = 0;
    int unsigned cycle_count = 0;
    int          stall_mode = 0;
    int unsigned stall_clock = 0;

    modbus_rtu_master_framer_top #(
        .MAX_FRAME(FRAME_MAX)
    ) u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_op               (i_op),
        .i_data_byte        (i_data_byte),
        .i_last_request_byte(i_last_request_byte),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_kind             (o_kind),
        .o_byte_value       (o_byte_value),
        .o_end_of_run       (o_end_of_run),
        .o_status           (o_status),
        .o_exception_code   (o_exception_code),
        .o_frame_length     (o_frame_length),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready)
    );

    always #1 i_clk = ~i_clk;

    // Watchdog: a run that has not finished by the limit has hung somewhere.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Result monitor and receiver. Values are sampled as they stood before the edge,
    // so a result counts as taken exactly when valid was high and stall was low.
    // The stall pattern changes character at regular intervals: never stalling,
    // stalling now and then, stalling most of the time, or a fixed periodic pattern.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_result({o_kind, o_byte_value, o_end_of_run, o_status,
                             o_exception_code, o_frame_length});
        end
        stall_clock++;
        if (stall_clock % 97 == 0) begin
            stall_mode = $urandom_range(0, 3);
        end
        case (stall_mode)
            0: i_out_stall <= 1'b0;
            1: i_out_stall <= ($urandom_range(0, 3) == 0);
            2: i_out_stall <= ($urandom_range(0, 3) != 0);
            default: i_out_stall <= ((stall_clock % 8) < 3);
        endcase
    end

    // Lowers valid and waits before returning; every caller passes a positive n, so
    // valid is never lowered and raised again within one time step.
    task automatic pause(input int n);
        i_in_valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // Presents one input transaction and waits for the edge that accepts it. Valid
    // stays high on return, so a following transaction can go out back to back.
    task automatic send(input logic [1:0] op, input logic [7:0] b, input logic last);
        if (!steady) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 16);
                pause($urandom_range(1, 6));
            end
            burst_left--;
        end
        i_op                <= op;
        i_data_byte         <= b;
        i_last_request_byte <= last;
        i_in_valid          <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        if (sb.accept_item(op, b, last)) begin
            live_items++;
        end
    endtask

    task automatic send_tick();
        send(OP_TICK, 8'($urandom), 1'($urandom));
    endtask

    // The sender holds back until every expected result has been taken.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.awaited.size() != 0);
    endtask

    // One APB write: setup cycle, access cycle, then an idle bus cycle.
    task automatic write_reg(input logic index, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_register(index, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // Registers change only while the framer is idle. A tick raises no result, so
    // after the last result the task waits on to let any such transaction settle
    // inside the block before the bus write.
    task automatic configure(input logic [15:0] timeout, input logic [7:0] gap);
        drain_results();
        repeat (4) @(posedge i_clk);
        write_reg(REG_TIMEOUT, {16'h0000, timeout});
        write_reg(REG_GAP, {24'h000000, gap});
    endtask

    // Sends ticks until the framer has closed its frame.
    task automatic close_out();
        while (sb.ph != PH_IDLE) begin
            send_tick();
        end
    endtask

    // A request followed by a reply of a random sort: none at all, too short, with a
    // corrupted CRC, an exception, or a well-formed one. Noise is mixed in: stale
    // line bytes, ticks or unused codes before the request, and request bytes or
    // unused codes during the reply, which the framer must ignore.
    task automatic run_frame();
        logic [7:0]  reply[$];
        logic [15:0] c;
        int          nreq;
        int          style;
        int          k;
        int          hold;
        steady = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 4) == 0) begin
            send(2'($urandom_range(1, 3)), 8'($urandom), 1'($urandom));
        end
        nreq = $urandom_range(1, 8);
        for (int i = 0; i < nreq; i++) begin
            send(OP_REQ, 8'($urandom), (i == nreq - 1));
        end
        if ($urandom_range(0, 5) == 0) begin
            drain_results();
        end
        style = $urandom_range(0, 9);
        if (style == 0 && sb.timeout_ticks > 40) begin
            style = 9;
        end
        if (style == 1) begin
            k = $urandom_range(1, 3);
            repeat (k) reply.push_back(8'($urandom));
        end else if (style != 0) begin
            reply.push_back(8'($urandom));
            if (style == 3) begin
                reply.push_back(8'($urandom) | 8'h80);
                reply.push_back(8'($urandom));
            end else begin
                reply.push_back(8'($urandom) & 8'h7F);
                k = $urandom_range(0, 6);
                repeat (k) reply.push_back(8'($urandom));
            end
            c = CRC_INIT;
            for (int i = 0; i < reply.size(); i++) begin
                c = frame_scoreboard::fold(c, reply[i]);
            end
            reply.push_back(c[7:0]);
            reply.push_back(c[15:8]);
            if (style == 2) begin
                k = $urandom_range(0, reply.size() - 1);
                reply[k] = reply[k] ^ (8'h01 << $urandom_range(0, 7));
            end
        end
        // Some silence before the first reply byte, short of the timeout.
        if (reply.size() != 0 && sb.timeout_ticks != 0) begin
            hold = (sb.timeout_ticks > 6) ? 5 : sb.timeout_ticks - 1;
            repeat ($urandom_range(0, hold)) send_tick();
        end
        for (int i = 0; i < reply.size(); i++) begin
            if ($urandom_range(0, 9) == 0) begin
                // Request byte without the last mark, so a broken frame never
                // starts a new wait behind our back.
                send(($urandom_range(0, 1) != 0) ? OP_REQ : 2'd3, 8'($urandom), 1'b0);
            end
            send(OP_RX, reply[i], 1'($urandom));
            if (i + 1 < reply.size()) begin
                // Mostly a gap shorter than the limit; now and then one that ends
                // the frame early, so the remaining bytes are stale.
                if ($urandom_range(0, 19) == 0) begin
                    k = sb.gap_ticks;
                end else begin
                    hold = (sb.gap_ticks > 4) ? 3 : sb.gap_ticks - 1;
                    k = $urandom_range(0, hold);
                end
                repeat (k) send_tick();
            end
        end
        close_out();
    endtask

    // A reply that fills the frame: the byte that reaches the maximum length also
    // closes it, and one more line byte afterwards is stale.
    task automatic run_full_frame();
        logic [7:0]  reply[$];
        logic [15:0] c;
        steady = ($urandom_range(0, 1) == 0);
        send(OP_REQ, 8'($urandom), 1'b1);
        c = CRC_INIT;
        for (int i = 0; i < FRAME_MAX - 2; i++) begin
            reply.push_back(8'($urandom));
            c = frame_scoreboard::fold(c, reply[i]);
        end
        reply.push_back(c[7:0]);
        reply.push_back(c[15:8]);
        for (int i = 0; i < reply.size(); i++) begin
            send(OP_RX, reply[i], 1'b0);
        end
        send(OP_RX, 8'($urandom), 1'b0);
        close_out();
    endtask

    initial begin
        logic [15:0] c;
        logic [15:0] timeouts[5];
        logic [7:0]  gaps[5];
        int          start;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part with a timeout of three ticks and a gap of one tick.
        configure(16'd3, 8'd1);
        steady = 1'b1;
        send(2'd3, 8'hFF, 1'b1);            // unused code
        send(OP_RX, 8'hAA, 1'b0);           // stale line byte while idle
        send(OP_TICK, 8'h55, 1'b1);         // tick while idle
        send(OP_REQ, 8'h00, 1'b0);
        send(OP_REQ, 8'hFF, 1'b1);          // last request byte: CRC follows
        send(OP_REQ, 8'h12, 1'b1);          // request byte while waiting
        send(OP_TICK, 8'h00, 1'b0);
        steady = 1'b0;
        c = CRC_INIT;
        c = frame_scoreboard::fold(c, 8'h11);
        c = frame_scoreboard::fold(c, 8'h83);
        c = frame_scoreboard::fold(c, 8'h02);
        send(OP_RX, 8'h11, 1'b0);
        send(OP_RX, 8'h83, 1'b1);           // function byte with the exception bit
        send(OP_RX, 8'h02, 1'b0);
        send(OP_RX, c[7:0], 1'b0);
        send(OP_RX, c[15:8], 1'b0);
        send(OP_TICK, 8'hFF, 1'b0);         // gap of one tick closes the frame
        send(OP_REQ, 8'hA5, 1'b1);
        repeat (3) send_tick();             // nothing comes back: no reply
        send(OP_REQ, 8'h01, 1'b1);
        send(OP_RX, 8'hFF, 1'b1);
        send(OP_TICK, 8'h00, 1'b1);         // one byte only: short frame
        send(OP_REQ, 8'h5A, 1'b1);
        repeat (4) send(OP_RX, 8'($urandom), 1'b0);
        send_tick();                        // four bytes, almost surely a bad CRC

        // Random part over several settings, the extreme timeouts among them.
        timeouts[0] = 16'd0;
        gaps[0]     = 8'd1;
        timeouts[1] = 16'hFFFF;
        gaps[1]     = 8'd24;
        timeouts[2] = TIMEOUT_RESET;
        gaps[2]     = GAP_RESET;
        timeouts[3] = 16'($urandom_range(1, 30));
        gaps[3]     = 8'($urandom_range(1, 6));
        timeouts[4] = 16'($urandom_range(0, 10));
        gaps[4]     = 8'($urandom_range(2, 12));
        for (int p = 0; p < 5; p++) begin
            configure(timeouts[p], gaps[p]);
            start = live_items;
            while (live_items - start < PHASE_ITEMS) begin
                run_frame();
            end
            if (p == 1) begin
                // The full frame, closed by its own length.
                run_full_frame();
            end
        end

        drain_results();
        repeat (8) @(posedge i_clk);
        sb.leftover_check();
        if (sb.errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

@@ files.f @@
design/mrmf_pkg.sv
design/mrmf_core.sv
design/mrmf_outbuf.sv
design/modbus_rtu_master_framer_top.sv
verif/mrmf_tb_pkg.sv
verif/tb_top.sv
